@@ rtl/core/svr_pkg.sv @@
// Package for the spherical vector register: payload types, constants and helper functions.
package svr_pkg;

   // Number of CORDIC iterations per pass (12 to 32).
   localparam int CORDIC_STEPS = 24;
   // Width that output coordinates saturate to (at most 32 is used).
   localparam int COORD_WIDTH  = 32;
   localparam int OUT_W        = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   // Internal coordinates are Q.20 in 48 bits, internal angles degrees Q.20 in 30 bits.
   localparam int IW = 48;
   localparam int AW = 30;

   localparam logic signed [AW-1:0] DEG90     = 30'sd94371840;
   localparam logic signed [AW-1:0] DEG180    = 30'sd188743680;
   localparam logic signed [15:0]   ANG_LIMIT = 16'sd23040;
   localparam logic [23:0]          GAIN_Q24  = 24'd10187857;

   localparam logic signed [AW-1:0] ATAN_TABLE [32] = '{
      30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
      30'sd3750059,  30'sd1876857,  30'sd938658,   30'sd469357,
      30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
      30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
      30'sd917,      30'sd458,      30'sd229,      30'sd115,
      30'sd57,       30'sd29,       30'sd14,       30'sd7,
      30'sd4,        30'sd2,        30'sd1,        30'sd0,
      30'sd0,        30'sd0,        30'sd0,        30'sd0
   };

   typedef enum logic [1:0] {
      OP_SET_SPH  = 2'd0,
      OP_SET_CART = 2'd1,
      OP_ADD_CART = 2'd2,
      OP_NONE     = 2'd3
   } svr_op_type;

   typedef struct packed {
      logic [1:0]          operation;
      logic signed [31:0]  coord_x;
      logic signed [31:0]  coord_y;
      logic signed [31:0]  coord_z;
      logic [31:0]         new_distance;
      logic signed [15:0]  new_azimuth;
      logic signed [15:0]  new_elevation;
   } svr_req_type;

   typedef struct packed {
      logic signed [31:0]  out_x;
      logic signed [31:0]  out_y;
      logic signed [31:0]  out_z;
      logic [31:0]         out_distance;
      logic signed [15:0]  out_azimuth;
      logic signed [15:0]  out_elevation;
      logic                saturated;
   } svr_rsp_type;

   typedef struct packed {
      logic                clip;
      logic signed [31:0]  value;
   } svr_sat_type;

   typedef struct packed {
      logic                clip;
      logic [31:0]         value;
   } svr_dist_type;

   // Degrees Q.20 to Q9.7, rounded half up and clamped to +-180 degrees.
   function automatic logic signed [15:0] angle_out(logic signed [AW-1:0] a);
      logic signed [AW-1:0] s;
      logic signed [AW-14:0] q;
      s = a + AW'(4096);
      q = s[AW-1:13];
      if (q > (AW-13)'(ANG_LIMIT))
         return ANG_LIMIT;
      else if (q < -(AW-13)'(ANG_LIMIT))
         return -ANG_LIMIT;
      else
         return q[15:0];
   endfunction

   // Q.20 coordinate to Q15.16, rounded and saturated to OUT_W bits.
   function automatic svr_sat_type coord_out(logic signed [IW-1:0] v);
      localparam logic signed [IW-1:0] LIM = IW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
      logic signed [IW-1:0] r;
      svr_sat_type o;
      r = (v + IW'(8)) >>> 4;
      o.clip = 1'b0;
      if (r > LIM) begin
         r = LIM;
         o.clip = 1'b1;
      end else if (r < -LIM - IW'(1)) begin
         r = -LIM - IW'(1);
         o.clip = 1'b1;
      end
      o.value = r[31:0];
      return o;
   endfunction

   // Q.20 magnitude to unsigned Q16.16 distance, rounded and saturated.
   function automatic svr_dist_type dist_out(logic signed [IW-1:0] v);
      logic signed [IW-1:0] r;
      svr_dist_type o;
      r = (v + IW'(8)) >>> 4;
      o.clip = 1'b0;
      if (r < 0)
         o.value = '0;
      else if (r > IW'(64'sh0000_0000_FFFF_FFFF)) begin
         o.value = 32'hFFFF_FFFF;
         o.clip = 1'b1;
      end else
         o.value = r[31:0];
      return o;
   endfunction

endpackage

@@ rtl/core/spherical_vector_register.sv @@
// Spherical vector register with a shared iterative CORDIC unit for coordinate conversion.
// One pass is a setup step, the CORDIC iterations, the gain multiply and a final step.
// Set spherical and no-op items take two passes, set Cartesian four and add displacement
// six; one item is in work at a time.
// The next beat can be accepted in the cycle after the result loads.
// Reset (synchronous) clears the stored vector to zero and empties the result register.
module spherical_vector_register (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  svr_pkg::svr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output svr_pkg::svr_rsp_type rsp_data
);
   import svr_pkg::*;

   // Sequencer phases. Each conversion pass runs START, ITER, GAIN, NEXT.
   typedef enum logic [2:0] {
      S_IDLE,
      S_CART,
      S_START,
      S_ITER,
      S_GAIN,
      S_NEXT,
      S_OUT
   } state_type;

   // Which conversion pass the CORDIC unit is running.
   typedef enum logic [1:0] {
      P_EL_ROT,
      P_AZ_ROT,
      P_AZ_VEC,
      P_EL_VEC
   } pass_type;

   state_type             state_ff;
   pass_type              pass_ff;
   logic                  final_ff;
   logic                  zero_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [1:0]            gsub_ff;

   // CORDIC working registers.
   logic signed [IW-1:0]  px_ff;
   logic signed [IW-1:0]  py_ff;
   logic signed [AW-1:0]  pa_ff;

   // Gained results and the partial product of the split gain multiply.
   logic signed [IW-1:0]  gx_ff;
   logic signed [IW-1:0]  gy_ff;
   logic [24:0]           part_ff;

   // Vertical coordinate held while the horizontal pass runs, and the displacement.
   logic signed [IW-1:0]  hold_y_ff;
   logic signed [IW-1:0]  dx_ff;
   logic signed [IW-1:0]  dy_ff;
   logic signed [IW-1:0]  dz_ff;

   // Stored vector.
   logic [31:0]           dist_ff;
   logic signed [15:0]    az_ff;
   logic signed [15:0]    el_ff;

   logic                  clip_ff;
   logic signed [31:0]    ox_ff;
   logic signed [31:0]    oy_ff;
   logic signed [31:0]    oz_ff;

   logic                  rsp_valid_ff;
   svr_rsp_type           rsp_ff;

   // One CORDIC micro-rotation, shared by both modes; only the direction rule differs:
   // rotation turns toward zero angle, vectoring turns toward zero y.
   logic                  cw;
   logic signed [IW-1:0]  sh_x;
   logic signed [IW-1:0]  sh_y;
   logic signed [AW-1:0]  atan_step;
   logic                  rot_mode;

   assign rot_mode  = (pass_ff == P_EL_ROT) || (pass_ff == P_AZ_ROT);
   assign cw        = rot_mode ? (pa_ff >= 0) : (py_ff <= 0);
   assign sh_x      = py_ff >>> step_ff;
   assign sh_y      = px_ff >>> step_ff;
   assign atan_step = ATAN_TABLE[5'(step_ff)];

   // Gain multiply: the 48-bit value is split into a low unsigned half and a high
   // signed half, each multiplied by the 24-bit gain on one shared multiplier.
   logic signed [IW-1:0]  gsrc;
   logic signed [24:0]    mul_a;
   logic signed [49:0]    prod;
   logic signed [49:0]    round_lo;
   logic signed [49:0]    sum_hi;

   assign gsrc     = gsub_ff[1] ? py_ff : px_ff;
   assign mul_a    = gsub_ff[0] ? {gsrc[IW-1], gsrc[IW-1:24]} : {1'b0, gsrc[23:0]};
   assign prod     = mul_a * $signed({1'b0, GAIN_Q24});
   assign round_lo = (prod + 50'sd8388608) >>> 24;
   assign sum_hi   = prod + $signed({25'd0, part_ff});

   // Rounded and saturated views at the end of passes.
   svr_sat_type           sat_x;
   svr_sat_type           sat_y;
   svr_sat_type           sat_z;
   svr_dist_type          dist_sat;
   logic signed [AW-1:0]  vec_ang;

   assign sat_x    = coord_out(gx_ff);
   assign sat_y    = coord_out(hold_y_ff);
   assign sat_z    = coord_out(gy_ff);
   assign dist_sat = dist_out(gx_ff);

   always_comb begin
      vec_ang = pa_ff;
      if (vec_ang > DEG180)
         vec_ang = DEG180;
      else if (vec_ang < -DEG180)
         vec_ang = -DEG180;
      if (zero_ff)
         vec_ang = '0;
   end

   // Input angle clamping for loading spherical values.
   logic signed [15:0]    in_az;
   logic signed [15:0]    in_el;
   logic                  in_clip;

   always_comb begin
      in_az   = req_data.new_azimuth;
      in_el   = req_data.new_elevation;
      in_clip = 1'b0;
      if (in_az > ANG_LIMIT) begin
         in_az = ANG_LIMIT;
         in_clip = 1'b1;
      end else if (in_az < -ANG_LIMIT) begin
         in_az = -ANG_LIMIT;
         in_clip = 1'b1;
      end
      if (in_el > ANG_LIMIT) begin
         in_el = ANG_LIMIT;
         in_clip = 1'b1;
      end else if (in_el < -ANG_LIMIT) begin
         in_el = -ANG_LIMIT;
         in_clip = 1'b1;
      end
   end

   logic                  req_take;
   logic signed [IW-1:0]  in_cx;
   logic signed [IW-1:0]  in_cy;
   logic signed [IW-1:0]  in_cz;

   assign req_take = req_valid && !req_stall;
   assign in_cx    = {{(IW-36){req_data.coord_x[31]}}, req_data.coord_x, 4'b0};
   assign in_cy    = {{(IW-36){req_data.coord_y[31]}}, req_data.coord_y, 4'b0};
   assign in_cz    = {{(IW-36){req_data.coord_z[31]}}, req_data.coord_z, 4'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dist_ff      <= '0;
         az_ff        <= '0;
         el_ff        <= '0;
      end else begin
         // The result register empties on its accepting edge unless a new result loads.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT))
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  clip_ff <= (req_data.operation == OP_SET_SPH) && in_clip;
                  dx_ff   <= in_cx;
                  dy_ff   <= in_cy;
                  dz_ff   <= in_cz;
                  final_ff <= (req_data.operation != OP_ADD_CART);
                  unique case (svr_op_type'(req_data.operation))
                     OP_SET_SPH: begin
                        dist_ff  <= req_data.new_distance;
                        az_ff    <= in_az;
                        el_ff    <= in_el;
                        state_ff <= S_CART;
                     end
                     OP_SET_CART: begin
                        // Straight to the horizontal vectoring pass on (x, z).
                        px_ff     <= in_cx;
                        py_ff     <= in_cz;
                        hold_y_ff <= in_cy;
                        pass_ff   <= P_AZ_VEC;
                        state_ff  <= S_START;
                     end
                     OP_ADD_CART, OP_NONE: begin
                        state_ff <= S_CART;
                     end
                     default: state_ff <= S_CART;
                  endcase
               end
            end

            // Begin a spherical to Cartesian conversion of the stored vector.
            S_CART: begin
               px_ff    <= {{(IW-36){1'b0}}, dist_ff, 4'b0};
               py_ff    <= '0;
               pa_ff    <= {{(AW-29){el_ff[15]}}, el_ff, 13'b0};
               pass_ff  <= P_EL_ROT;
               state_ff <= S_START;
            end

            // Bring the operand into the range the iterations converge over.
            S_START: begin
               step_ff <= '0;
               if (rot_mode) begin
                  if (pa_ff > DEG90) begin
                     px_ff <= -px_ff;
                     py_ff <= -py_ff;
                     pa_ff <= pa_ff - DEG180;
                  end else if (pa_ff < -DEG90) begin
                     px_ff <= -px_ff;
                     py_ff <= -py_ff;
                     pa_ff <= pa_ff + DEG180;
                  end
               end else begin
                  zero_ff <= (px_ff == 0) && (py_ff == 0);
                  if (px_ff < 0) begin
                     pa_ff <= (py_ff >= 0) ? DEG180 : -DEG180;
                     px_ff <= -px_ff;
                     py_ff <= -py_ff;
                  end else
                     pa_ff <= '0;
               end
               state_ff <= S_ITER;
            end

            S_ITER: begin
               if (cw) begin
                  px_ff <= px_ff - sh_x;
                  py_ff <= py_ff + sh_y;
                  pa_ff <= pa_ff - atan_step;
               end else begin
                  px_ff <= px_ff + sh_x;
                  py_ff <= py_ff - sh_y;
                  pa_ff <= pa_ff + atan_step;
               end
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  gsub_ff  <= '0;
                  state_ff <= S_GAIN;
               end
            end

            // Low half of x, high half of x, low half of y, high half of y.
            S_GAIN: begin
               if (!gsub_ff[0])
                  part_ff <= round_lo[24:0];
               else if (!gsub_ff[1])
                  gx_ff <= sum_hi[IW-1:0];
               else
                  gy_ff <= sum_hi[IW-1:0];
               gsub_ff <= gsub_ff + 2'd1;
               if (gsub_ff == 2'd3)
                  state_ff <= S_NEXT;
            end

            S_NEXT: begin
               unique case (pass_ff)
                  P_EL_ROT: begin
                     hold_y_ff <= gy_ff;
                     px_ff     <= gx_ff;
                     py_ff     <= '0;
                     pa_ff     <= {{(AW-29){az_ff[15]}}, az_ff, 13'b0};
                     pass_ff   <= P_AZ_ROT;
                     state_ff  <= S_START;
                  end
                  P_AZ_ROT: begin
                     if (final_ff) begin
                        ox_ff    <= sat_x.value;
                        oy_ff    <= sat_y.value;
                        oz_ff    <= sat_z.value;
                        clip_ff  <= clip_ff | sat_x.clip | sat_y.clip | sat_z.clip;
                        state_ff <= S_OUT;
                     end else begin
                        // Add the displacement, then convert back to spherical form.
                        px_ff     <= gx_ff + dx_ff;
                        py_ff     <= gy_ff + dz_ff;
                        hold_y_ff <= hold_y_ff + dy_ff;
                        pass_ff   <= P_AZ_VEC;
                        state_ff  <= S_START;
                     end
                  end
                  P_AZ_VEC: begin
                     az_ff    <= angle_out(vec_ang);
                     px_ff    <= gx_ff;
                     py_ff    <= hold_y_ff;
                     pass_ff  <= P_EL_VEC;
                     state_ff <= S_START;
                  end
                  P_EL_VEC: begin
                     el_ff    <= angle_out(vec_ang);
                     dist_ff  <= dist_sat.value;
                     clip_ff  <= clip_ff | dist_sat.clip;
                     final_ff <= 1'b1;
                     state_ff <= S_CART;
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end

            // Hand the result over once the output register is free.
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.out_x         <= ox_ff;
                  rsp_ff.out_y         <= oy_ff;
                  rsp_ff.out_z         <= oz_ff;
                  rsp_ff.out_distance  <= dist_ff;
                  rsp_ff.out_azimuth   <= az_ff;
                  rsp_ff.out_elevation <= el_ff;
                  rsp_ff.saturated     <= clip_ff;
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/sv/tb_spherical_vector_register.sv @@
// Testbench for the spherical vector register: random and directed beats checked by a scoreboard.
`timescale 1ns / 1ps

// Scoreboard that keeps its own copy of the stored vector and the results it should produce.
class svr_scoreboard;
   localparam longint DEG90_Q20  = 64'sd90 * 64'sd1048576;
   localparam longint DEG180_Q20 = 64'sd180 * 64'sd1048576;
   localparam longint ANG_LIM    = 64'sd23040;

   bit [31:0] distance;
   int        azimuth;
   int        elevation;
   bit        clipped;
   int        errors;
   svr_pkg::svr_rsp_type pending[$];

   function new();
      distance  = '0;
      azimuth   = 0;
      elevation = 0;
      errors    = 0;
   endfunction

   // Round half up, then shift arithmetically.
   function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function longint apply_gain(longint v);
      return round_shift(v * longint'(svr_pkg::GAIN_Q24), 24);
   endfunction

   function int step_count();
      return (svr_pkg::CORDIC_STEPS > 32) ? 32 : svr_pkg::CORDIC_STEPS;
   endfunction

   // Rotation mode: turns (x,y) by ang degrees Q.20.
   function void rotate(inout longint x, inout longint y, input longint ang);
      longint dx, dy;
      if (ang > DEG90_Q20) begin
         x = -x; y = -y; ang -= DEG180_Q20;
      end else if (ang < -DEG90_Q20) begin
         x = -x; y = -y; ang += DEG180_Q20;
      end
      for (int i = 0; i < step_count(); i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (ang >= 0) begin
            x -= dx; y += dy; ang -= longint'(svr_pkg::ATAN_TABLE[i]);
         end else begin
            x += dx; y -= dy; ang += longint'(svr_pkg::ATAN_TABLE[i]);
         end
      end
      x = apply_gain(x);
      y = apply_gain(y);
   endfunction

   // Vectoring mode: magnitude and four-quadrant angle of (x,y).
   function void vectorize(input longint x, input longint y, output longint mag,
                           output longint ang);
      longint a, dx, dy;
      a = 0;
      if (x == 0 && y == 0) begin
         mag = 0; ang = 0;
         return;
      end
      if (x < 0) begin
         a = (y >= 0) ? DEG180_Q20 : -DEG180_Q20;
         x = -x; y = -y;
      end
      for (int i = 0; i < step_count(); i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; a += longint'(svr_pkg::ATAN_TABLE[i]);
         end else begin
            x -= dx; y += dy; a -= longint'(svr_pkg::ATAN_TABLE[i]);
         end
      end
      if (a > DEG180_Q20) a = DEG180_Q20;
      if (a < -DEG180_Q20) a = -DEG180_Q20;
      mag = apply_gain(x);
      ang = a;
   endfunction

   function void to_cartesian(output longint x, output longint y, output longint z);
      longint h, v;
      h = longint'(distance) * 16;
      v = 0;
      rotate(h, v, longint'(elevation) * 8192);
      y = v;
      x = h;
      z = 0;
      rotate(x, z, longint'(azimuth) * 8192);
   endfunction

   function int angle_q7(longint a);
      longint q;
      q = round_shift(a, 13);
      if (q > ANG_LIM) q = ANG_LIM;
      if (q < -ANG_LIM) q = -ANG_LIM;
      return int'(q);
   endfunction

   function void to_spherical(longint x, longint y, longint z);
      longint h, az, d, el, q;
      vectorize(x, z, h, az);
      vectorize(h, y, d, el);
      q = round_shift(d, 4);
      if (q < 0) q = 0;
      if (q > 64'sh0000_0000_FFFF_FFFF) begin
         q = 64'sh0000_0000_FFFF_FFFF;
         clipped = 1'b1;
      end
      distance  = q[31:0];
      azimuth   = angle_q7(az);
      elevation = angle_q7(el);
   endfunction

   function int clamp_angle(logic signed [15:0] raw);
      int a;
      a = raw;
      if (a > ANG_LIM) begin
         a = int'(ANG_LIM); clipped = 1'b1;
      end
      if (a < -ANG_LIM) begin
         a = int'(-ANG_LIM); clipped = 1'b1;
      end
      return a;
   endfunction

   function logic [31:0] coord_q16(longint v);
      longint lim, q;
      lim = (64'sd1 <<< (svr_pkg::OUT_W - 1)) - 1;
      q = round_shift(v, 4);
      if (q > lim) begin
         q = lim; clipped = 1'b1;
      end
      if (q < -lim - 1) begin
         q = -lim - 1; clipped = 1'b1;
      end
      return q[31:0];
   endfunction

   // Updates the model vector for an accepted request beat and queues its result.
   function void note_request(svr_pkg::svr_req_type req);
      longint cx, cy, cz, x, y, z;
      svr_pkg::svr_rsp_type rsp;
      cx = longint'(req.coord_x) * 16;
      cy = longint'(req.coord_y) * 16;
      cz = longint'(req.coord_z) * 16;
      clipped = 1'b0;
      case (svr_pkg::svr_op_type'(req.operation))
         svr_pkg::OP_SET_SPH: begin
            distance  = req.new_distance;
            azimuth   = clamp_angle(req.new_azimuth);
            elevation = clamp_angle(req.new_elevation);
         end
         svr_pkg::OP_SET_CART: begin
            to_spherical(cx, cy, cz);
         end
         svr_pkg::OP_ADD_CART: begin
            to_cartesian(x, y, z);
            to_spherical(x + cx, y + cy, z + cz);
         end
         default: ;
      endcase
      to_cartesian(x, y, z);
      rsp.out_x         = coord_q16(x);
      rsp.out_y         = coord_q16(y);
      rsp.out_z         = coord_q16(z);
      rsp.out_distance  = distance;
      rsp.out_azimuth   = azimuth[15:0];
      rsp.out_elevation = elevation[15:0];
      rsp.saturated     = clipped;
      pending.push_back(rsp);
   endfunction

   // Compares a response beat with the oldest queued result.
   function void check_response(svr_pkg::svr_rsp_type got);
      svr_pkg::svr_rsp_type want;
      if (pending.size() == 0) begin
         $error("unexpected response beat %h", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.out_x !== want.out_x) begin
         $error("out_x expected %0d actual %0d", want.out_x, got.out_x); errors++;
      end
      if (got.out_y !== want.out_y) begin
         $error("out_y expected %0d actual %0d", want.out_y, got.out_y); errors++;
      end
      if (got.out_z !== want.out_z) begin
         $error("out_z expected %0d actual %0d", want.out_z, got.out_z); errors++;
      end
      if (got.out_distance !== want.out_distance) begin
         $error("out_distance expected %0d actual %0d", want.out_distance,
                got.out_distance);
         errors++;
      end
      if (got.out_azimuth !== want.out_azimuth) begin
         $error("out_azimuth expected %0d actual %0d", want.out_azimuth, got.out_azimuth);
         errors++;
      end
      if (got.out_elevation !== want.out_elevation) begin
         $error("out_elevation expected %0d actual %0d", want.out_elevation,
                got.out_elevation);
         errors++;
      end
      if (got.saturated !== want.saturated) begin
         $error("saturated expected %0b actual %0b", want.saturated, got.saturated);
         errors++;
      end
   endfunction
endclass

module tb_spherical_vector_register;
   import svr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   svr_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   svr_rsp_type rsp_data;

   svr_scoreboard board = new();

   // Bursts of the sender: beats left in the current burst before a possible gap.
   int burst_left = 0;

   spherical_vector_register dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // The receiver switches between open stretches, light stalling and heavy stalling.
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Every accepted response beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_data);
   end

   // Drives one request beat and holds it until accepted; the beat is noted at acceptance.
   // Between bursts the valid may be dropped for a random gap, so no beat is lowered and raised
   // again within one time step.
   task automatic send_beat(svr_req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 6);
         if ($urandom_range(0, 1)) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 120)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_op(svr_op_type op, int x, int y, int z, logic [31:0] d,
                          logic [15:0] az, logic [15:0] el);
      svr_req_type item;
      item.operation     = op;
      item.coord_x       = x;
      item.coord_y       = y;
      item.coord_z       = z;
      item.new_distance  = d;
      item.new_azimuth   = az;
      item.new_elevation = el;
      send_beat(item);
   endtask

   // Coordinates over many magnitudes; full-range values hit the overflow paths.
   function automatic logic [31:0] pick_coord();
      logic signed [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0:       return v;
         1:       return v >>> $urandom_range(8, 31);
         default: return v >>> $urandom_range(2, 14);
      endcase
   endfunction

   // Angles are mostly legal, sometimes anywhere in the 16-bit range.
   function automatic logic [15:0] pick_angle();
      if ($urandom_range(0, 7) == 0)
         return 16'($urandom);
      return 16'($signed($urandom_range(0, 46080)) - 23040);
   endfunction

   initial begin
      svr_req_type item;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset view, angle limits, zero vectors, distance and coordinate
      // overflow, elevations past vertical and the unused operation code.
      send_op(OP_NONE,     0, 0, 0, 32'd0, 16'd0, 16'd0);
      send_op(OP_SET_SPH,  0, 0, 0, 32'h0001_0000, 16'sd0, 16'sd0);
      send_op(OP_SET_SPH,  0, 0, 0, 32'hFFFF_FFFF, 16'sd23040, 16'sd0);
      send_op(OP_SET_SPH,  0, 0, 0, 32'hFFFF_FFFF, -16'sd23040, 16'sd11520);
      send_op(OP_SET_SPH,  0, 0, 0, 32'h0010_0000, 16'sh7FFF, 16'sh8000);
      send_op(OP_SET_SPH,  0, 0, 0, 32'h0010_0000, 16'sh8000, 16'sh7FFF);
      send_op(OP_SET_SPH,  0, 0, 0, 32'h0020_0000, 16'sd5760, 16'sd17280);
      send_op(OP_SET_SPH,  0, 0, 0, 32'h0020_0000, -16'sd17280, -16'sd20000);
      send_op(OP_NONE,     -1, -1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_op(OP_SET_CART, 0, 0, 0, 32'd0, 16'd0, 16'd0);
      send_op(OP_SET_CART, 0, 32'sh0001_0000, 0, 32'd0, 16'd0, 16'd0);
      send_op(OP_SET_CART, -32'sh0001_0000, 0, 0, 32'd0, 16'd0, 16'd0);
      send_op(OP_SET_CART, -32'sh0001_0000, 0, -32'sh0000_8000, 32'd0, 16'd0, 16'd0);
      send_op(OP_SET_CART, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'd0, 16'd0, 16'd0);
      send_op(OP_SET_CART, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'd0, 16'd0, 16'd0);
      send_op(OP_SET_CART, 32'sh8000_0000, 0, 0, 32'd0, 16'd0, 16'd0);
      send_op(OP_SET_CART, 32'sh0003_0000, -32'sh0004_0000, 32'sh0005_0000,
              32'd0, 16'd0, 16'd0);
      send_op(OP_ADD_CART, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
              32'd0, 16'd0, 16'd0);
      send_op(OP_ADD_CART, -32'sh0004_0000, 32'sh0003_0000, -32'sh0006_0000,
              32'd0, 16'd0, 16'd0);
      send_op(OP_SET_SPH,  0, 0, 0, 32'h0000_0001, 16'sd100, 16'sd100);
      send_op(OP_ADD_CART, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'd0, 16'd0, 16'd0);
      send_op(OP_ADD_CART, 0, 0, 0, 32'd0, 16'd0, 16'd0);

      // Random part: mostly real operations, occasional unused code.
      repeat (600) begin
         item.operation     = ($urandom_range(0, 19) == 0) ? OP_NONE :
                              svr_op_type'($urandom_range(0, 2));
         item.coord_x       = pick_coord();
         item.coord_y       = pick_coord();
         item.coord_z       = pick_coord();
         item.new_distance  = $urandom >> $urandom_range(0, 20);
         item.new_azimuth   = pick_angle();
         item.new_elevation = pick_angle();
         send_beat(item);
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb_spherical_vector_register: PASS");
      end else begin
         $display("tb_spherical_vector_register: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("tb_spherical_vector_register: FAIL");
      $finish;
   end
endmodule

@@ spherical_vector_register.f @@
rtl/core/svr_pkg.sv
rtl/core/spherical_vector_register.sv
tb/sv/tb_spherical_vector_register.sv
